// ===== sv/positional_insert_erase_list_defines.svh =====
// ----------------------------------------------------------------------------
// Positional insert/erase list assertion macros
// Shared property wrappers for the list's port checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_ERASE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define PILIST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define PILIST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pilist_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional insert/erase list package
// Word types, operation codes and shared constants of the list.
// ----------------------------------------------------------------------------
package pilist_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 6;
  localparam int MODE_W       = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]       entry_count_out;
  } out_word_t;

  // Broadcast command that every cell sees in the cycle an item is accepted.
  typedef struct packed {
    logic                     insert_en;
    logic                     erase_en;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/positional_insert_erase_list.sv =====
// ----------------------------------------------------------------------------
// Positional insert/erase list
// Fixed-capacity ordered list built as a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Transfer
//   input     start, busy, in_word         taken when start is high, busy low
//   result    out_valid, out_word          one-cycle strobe, cannot be held
//
// Every word takes one clock cycle: its result appears on out_word with
// out_valid in the cycle after it is taken, and a new word may be taken in
// that same cycle. That pace comes from the row of cells, which all
// shift at once, so an insert or erase moves every later entry together.
// Synchronous reset empties the list and clears every slot; no clearing
// pass follows it. The result side has no stall, so busy never rises.
//
module positional_insert_erase_list #(
  parameter int CAPACITY = pilist_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  pilist_pkg::in_word_t  in_word,
  output logic                  out_valid,
  output pilist_pkg::out_word_t out_word
);

  localparam logic [pilist_pkg::COUNT_W-1:0] CAP_COUNT =
    pilist_pkg::COUNT_W'(CAPACITY);

  // Each word is handled by the row of cells with no stall, so the list is never busy.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [pilist_pkg::COUNT_W-1:0] count_r;
  logic [pilist_pkg::COUNT_W-1:0] count_nxt;
  logic                           out_valid_r;
  pilist_pkg::out_word_t          out_word_r;
  pilist_pkg::out_word_t          out_word_nxt;

  // Range checks against the current fill level. Insert may land one past
  // the last entry; erase and read must hit an existing entry.
  logic insert_ok;
  logic erase_ok;
  logic read_ok;

  assign insert_ok = accept && (in_word.mode == pilist_pkg::MODE_INSERT) &&
                     (in_word.position <= count_r) && (count_r < CAP_COUNT);
  assign erase_ok  = accept && (in_word.mode == pilist_pkg::MODE_ERASE) &&
                     (in_word.position < count_r);
  assign read_ok   = accept && (in_word.mode == pilist_pkg::MODE_READ) &&
                     (in_word.position < count_r);

  pilist_pkg::cell_cmd_t cmd;
  always_comb begin
    cmd.insert_en = insert_ok;
    cmd.erase_en  = erase_ok;
    cmd.position  = in_word.position;
    cmd.value     = in_word.value;
  end

  // The row of cells. Cell zero has nothing below it and the top cell takes
  // zero from above, which clears the slot freed at the old top on erase.
  logic signed [pilist_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [pilist_pkg::DATA_W-1:0] cell_tap  [CAPACITY];

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [pilist_pkg::DATA_W-1:0] lower;
    logic signed [pilist_pkg::DATA_W-1:0] upper;

    if (gi == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[gi+1];
    end

    pilist_cell #(
      .INDEX(gi)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .lower_data(lower),
      .upper_data(upper),
      .data      (cell_data[gi]),
      .read_tap  (cell_tap[gi])
    );
  end

  // Only the cell at the requested position drives a nonzero tap, so the
  // read value is the OR of all taps.
  logic signed [pilist_pkg::DATA_W-1:0] tap_or;
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (insert_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (erase_ok) begin
      count_nxt = count_r - 1'b1;
    end
    out_word_nxt.accepted        = insert_ok || erase_ok || read_ok;
    out_word_nxt.read_data       = read_ok ? tap_or : '0;
    out_word_nxt.entry_count_out = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // The result word is payload only; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/pilist_cell.sv =====
// ----------------------------------------------------------------------------
// Positional insert/erase list cell
// One slot of the list; shifts with its neighbors on insert and erase.
// ----------------------------------------------------------------------------
module pilist_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pilist_pkg::cell_cmd_t               cmd,
  input  logic signed [pilist_pkg::DATA_W-1:0] lower_data,
  input  logic signed [pilist_pkg::DATA_W-1:0] upper_data,
  output logic signed [pilist_pkg::DATA_W-1:0] data,
  output logic signed [pilist_pkg::DATA_W-1:0] read_tap
);

  localparam logic [pilist_pkg::POS_W-1:0] MY_POS = pilist_pkg::POS_W'(INDEX);

  logic signed [pilist_pkg::DATA_W-1:0] data_r;
  logic signed [pilist_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.insert_en) begin
      // Slots above the insert point take the entry from below.
      if (MY_POS > cmd.position) begin
        data_nxt = lower_data;
      end else if (MY_POS == cmd.position) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.erase_en) begin
      // Slots at or above the erase point take the entry from above.
      if (MY_POS >= cmd.position) begin
        data_nxt = upper_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data     = data_r;
  assign read_tap = (MY_POS == cmd.position) ? data_r : '0;

endmodule

// ===== sv/pilist_checker.sv =====
// ----------------------------------------------------------------------------
// Positional insert/erase list checker
// Port-level assertions on result timing and result contents.
// ----------------------------------------------------------------------------
`include "positional_insert_erase_list_defines.svh"

module pilist_checker #(
  parameter int CAPACITY = pilist_pkg::CAPACITY_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input pilist_pkg::in_word_t  in_word,
  input logic                  out_valid,
  input pilist_pkg::out_word_t out_word
);

  localparam logic [pilist_pkg::COUNT_W-1:0] CAP_COUNT =
    pilist_pkg::COUNT_W'(CAPACITY);

  logic taken;
  assign taken = start && !busy;

  `PILIST_ASSERT_NEXT(a_result_follows, taken, out_valid, "taken word gave no result")
  `PILIST_ASSERT_NEXT(a_no_spurious, !taken, !out_valid, "result without a taken word")
  `PILIST_ASSERT_SAME(a_count_bound, out_valid, out_word.entry_count_out <= CAP_COUNT, "count above capacity")
  `PILIST_ASSERT_SAME(a_refused_zero, out_valid && !out_word.accepted, out_word.read_data == '0, "refused word returned data")
  `PILIST_ASSERT_SAME(a_insert_nonempty, out_valid && out_word.accepted && ($past(in_word.mode) == pilist_pkg::MODE_INSERT), out_word.entry_count_out != '0, "list empty after insert")

endmodule

bind positional_insert_erase_list pilist_checker #(
  .CAPACITY(CAPACITY)
) u_pilist_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_word (out_word)
);
